/* design/synced_joint_linear_trajectory_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the synced joint linear trajectory block
// Shared helpers that wrap a clocked, reset-qualified implication.
// ----------------------------------------------------------------------------
`ifndef SYNCED_JOINT_LINEAR_TRAJECTORY_MACROS_SVH
`define SYNCED_JOINT_LINEAR_TRAJECTORY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SJLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sjlt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SJLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sjlt: next-cycle check failed");

`endif

/* design/sjlt_pkg.sv */
// ----------------------------------------------------------------------------
// sjlt_pkg
// Types, codes and small arithmetic helpers for the joint trajectory block.
// ----------------------------------------------------------------------------
package sjlt_pkg;

    localparam int JOINT_FIELDS      = 6;
    localparam int DEF_JOINTS        = 6;
    localparam int DEF_MAX_WAYPOINTS = 256;
    localparam int QW                = 32;
    localparam int CFG_IDX_W         = 3;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_JOINTS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_BASE = 3'd1;

    localparam logic [2:0]    JOINTS_RESET = 3'd6;
    localparam logic [QW-1:0] VEL_RESET    = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] joint_in_0;
        logic signed [31:0] joint_in_1;
        logic signed [31:0] joint_in_2;
        logic signed [31:0] joint_in_3;
        logic signed [31:0] joint_in_4;
        logic signed [31:0] joint_in_5;
        logic [31:0]       time_value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] joint_out_0;
        logic signed [31:0] joint_out_1;
        logic signed [31:0] joint_out_2;
        logic signed [31:0] joint_out_3;
        logic signed [31:0] joint_out_4;
        logic signed [31:0] joint_out_5;
        logic [31:0]       segment_time;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [2*QW-1:0]   dividend;
        logic [QW-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QW-1:0]     quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_LAT,
        S_JDIV,
        S_JWAIT,
        S_SEG_WR,
        S_CL_RD0,
        S_CL_RD1,
        S_CL_LAT,
        S_CL_DIV,
        S_CL_DWAIT,
        S_SM_RD,
        S_SM_CHK,
        S_SM_WRD0,
        S_SM_WRD1,
        S_SM_WLAT,
        S_SM_MUL,
        S_SM_POS,
        S_SM_END_RD,
        S_SM_END_LAT,
        S_DONE
    } state_t;

    // Unsigned add that sticks at all ones.
    function automatic logic [QW-1:0] sat_add32(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QW] ? '1 : s[QW-1:0];
    endfunction

    // Magnitude of b - a; always fits in 32 bits.
    function automatic logic [QW-1:0] abs_delta(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [QW:0] d;
        logic [QW:0] n;
        d = {b[31], b} - {a[31], a};
        n = -d;
        return d[QW] ? n[QW-1:0] : d[QW-1:0];
    endfunction

    // Start position moved by an unsigned increment, clamped to 32-bit signed.
    function automatic logic signed [31:0] sat_pos(input logic signed [31:0] a,
                                                   input logic [47:0] inc,
                                                   input logic down);
        logic [49:0] ax;
        logic [49:0] ix;
        logic [49:0] p;
        logic signed [31:0] r;
        ax = {{18{a[31]}}, a};
        ix = {2'b00, inc};
        p  = down ? (ax - ix) : (ax + ix);
        if (p[49:31] == '0 || p[49:31] == '1)
        begin
            r = p[31:0];
        end
        else if (p[49])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

/* design/synced_joint_linear_trajectory.sv */
// ----------------------------------------------------------------------------
// synced_joint_linear_trajectory
// Synchronized multi-joint linear interpolation over stored Q16.16 waypoints.
// ----------------------------------------------------------------------------
// The block keeps joint waypoints and per-segment timing in two synchronous
// memories (one for waypoints, one for duration plus per-joint speed) and
// handles one item at a time. An add item stores the waypoint and, from the
// second one on, times the new segment: the duration is the slowest joint's
// |delta|/limit and each joint's speed is |delta|/duration. A close item ends
// the open batch and, when the target time is longer than the batch's
// natural time, rescales each batch segment (or splits the target equally)
// and recomputes its speeds. A sample item walks the closed segments and
// returns start plus signed speed times elapsed time per joint. Every
// quotient goes through one shared divider that produces a bit per cycle,
// so that unit sets the rate of adds and closes. A sample walks its closed
// segments through one memory read port with registered data. The stores
// need no clearing after reset. A finished result waits in an output
// register, so the next item is taken while it is still unread.
// Configuration is written through a plain write port; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module synced_joint_linear_trajectory
    import sjlt_pkg::*;
#(
    parameter int JOINTS        = DEF_JOINTS,
    parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QW-1:0]        cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res
);

    localparam int AW   = $clog2(MAX_WAYPOINTS);
    localparam int CW   = $clog2(MAX_WAYPOINTS + 1);
    localparam int JCW  = $clog2(JOINTS + 1);
    localparam int ACCW = QW + AW;
    localparam int WPW  = JOINTS * QW;
    localparam int SGW  = (JOINTS + 1) * QW;

    // Storage: waypoints, and per segment {duration, speeds}.
    logic [WPW-1:0] wp_mem  [MAX_WAYPOINTS];
    logic [SGW-1:0] seg_mem [MAX_WAYPOINTS];

    logic [WPW-1:0] wp_rdata_reg;
    logic [SGW-1:0] seg_rdata_reg;
    logic [AW-1:0]  wp_raddr;
    logic           wp_we;
    logic [WPW-1:0] wp_wdata;
    logic           seg_we;
    logic [SGW-1:0] seg_wdata;

    // Configuration.
    logic [2:0]    joints_in_use_reg;
    logic [QW-1:0] vel_limit_reg [JOINT_FIELDS];

    // Trajectory bookkeeping.
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] first_reg;
    logic [QW-1:0] min_sum_reg;
    logic [QW-1:0] total_reg;

    // Control and datapath.
    state_t         state_reg;
    state_t         state_next;
    req_t           req_reg;
    logic [JCW-1:0] j_reg;
    logic           spd_phase_reg;
    logic [AW-1:0]  i_reg;
    logic [QW-1:0]  dur_reg;
    logic [QW-1:0]  dur_old_reg;
    logic [ACCW-1:0] acc_reg;
    logic [QW-1:0]  el_reg;
    logic [2*QW-1:0] prod_reg;
    logic [1:0]     status_reg;
    logic [QW-1:0]  seg_time_reg;
    logic signed [31:0] a_reg   [JOINTS];
    logic signed [31:0] b_reg   [JOINTS];
    logic [QW-1:0]      lim_reg [JOINTS];
    logic [QW-1:0]      spd_reg [JOINTS];
    logic signed [31:0] pos_reg [JOINTS];
    res_t           res_reg;
    logic           res_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic signed [31:0] req_joint [JOINT_FIELDS];
    logic signed [31:0] pos_full  [JOINT_FIELDS];

    logic            accept;
    logic            load_res;
    logic [2:0]      n_act;
    logic [AW-1:0]   nseg_w;
    logic [AW-1:0]   nb_w;
    logic            adjust_w;
    logic            sample_bad_w;
    logic            full_w;
    logic [QW-1:0]   num_w;
    logic [QW-1:0]   den_w;
    logic            jact;
    logic            jsat;
    logic            jlast;
    logic            jstep;
    logic [QW-1:0]   jres;
    logic [QW-1:0]   seg_dur_w;
    logic [ACCW-1:0] acc_next;
    logic            found_w;
    logic            cl_last_w;
    logic [QW-1:0]   mul_a;
    logic [QW-1:0]   mul_b;

    sjlt_div u_div
    (
        .clk  (clk),
        .rst_n(rst_n),
        .dreq (dreq),
        .drsp (drsp)
    );

    assign req_joint[0] = req_reg.joint_in_0;
    assign req_joint[1] = req_reg.joint_in_1;
    assign req_joint[2] = req_reg.joint_in_2;
    assign req_joint[3] = req_reg.joint_in_3;
    assign req_joint[4] = req_reg.joint_in_4;
    assign req_joint[5] = req_reg.joint_in_5;

    for (genvar g = 0; g < JOINT_FIELDS; g++)
    begin : g_pos
        if (g < JOINTS)
        begin : g_used
            assign pos_full[g] = pos_reg[g];
        end
        else
        begin : g_unused
            assign pos_full[g] = '0;
        end
    end

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign load_res  = (state_reg == S_DONE) && (!res_valid_reg || res_ready);

    // Joints in use: zero acts as one, anything past JOINTS as JOINTS.
    always_comb
    begin
        n_act = joints_in_use_reg;
        if (joints_in_use_reg == 3'd0)
        begin
            n_act = 3'd1;
        end
        else if (joints_in_use_reg > 3'(JOINTS))
        begin
            n_act = 3'(JOINTS);
        end
    end

    assign nseg_w       = (cnt_reg == '0) ? '0 : AW'(cnt_reg - 1'b1);
    assign nb_w         = nseg_w - first_reg;
    assign adjust_w     = (req.time_value > min_sum_reg) && (nb_w != '0);
    assign sample_bad_w = (req.time_value > total_reg) || (first_reg == '0)
                          || (CW'(first_reg) >= cnt_reg);
    assign full_w       = cnt_reg >= CW'(MAX_WAYPOINTS);
    assign cl_last_w    = (i_reg == nseg_w - 1'b1);

    // Per-joint quotient step; joint data rotates so element 0 is current.
    assign num_w = abs_delta(a_reg[0], b_reg[0]);
    assign den_w = spd_phase_reg ? dur_reg : lim_reg[0];
    assign jact  = (3'(j_reg) < n_act) && (den_w != '0);
    // Quotient of (num << 16) / den overflows 32 bits exactly when num >> 16 >= den.
    assign jsat  = {16'b0, num_w[QW-1:16]} >= den_w;
    assign jlast = (j_reg == JCW'(JOINTS - 1));
    assign jstep = ((state_reg == S_JDIV) && (!jact || jsat))
                   || ((state_reg == S_JWAIT) && drsp.done);
    assign jres  = (state_reg == S_JWAIT) ? drsp.quotient : (jact ? '1 : '0);

    // Segment walk for samples.
    assign seg_dur_w = seg_rdata_reg[SGW-1 -: QW];
    assign acc_next  = acc_reg + ACCW'(seg_dur_w);
    assign found_w   = ACCW'(req_reg.time_value) < acc_next;

    // Shared divider request.
    always_comb
    begin
        dreq.start    = ((state_reg == S_JDIV) && jact && !jsat) || (state_reg == S_CL_DIV);
        dreq.dividend = {16'b0, num_w, 16'b0};
        dreq.divisor  = den_w;
        if (state_reg == S_CL_DIV)
        begin
            if (min_sum_reg != '0)
            begin
                dreq.dividend = prod_reg;
                dreq.divisor  = min_sum_reg;
            end
            else
            begin
                dreq.dividend = {{QW{1'b0}}, req_reg.time_value};
                dreq.divisor  = QW'(nb_w);
            end
        end
    end

    // One shared multiplier: rescale product on close, increment on sample.
    assign mul_a = (state_reg == S_CL_LAT) ? req_reg.time_value : spd_reg[0];
    assign mul_b = (state_reg == S_CL_LAT) ? dur_old_reg : el_reg;

    // Memory ports.
    always_comb
    begin
        wp_raddr = i_reg;
        case (state_reg)
            S_ADD_RD:                 wp_raddr = AW'(cnt_reg - 1'b1);
            S_CL_RD1, S_SM_WRD1:      wp_raddr = i_reg + 1'b1;
            S_SM_END_RD:              wp_raddr = first_reg;
            default:                  wp_raddr = i_reg;
        endcase
    end

    assign wp_we  = (state_reg == S_ADD_RD);
    assign seg_we = (state_reg == S_SEG_WR);

    always_comb
    begin
        wp_wdata  = '0;
        seg_wdata = '0;
        for (int k = 0; k < JOINTS; k++)
        begin
            wp_wdata[k*QW +: QW]  = req_joint[k];
            seg_wdata[k*QW +: QW] = spd_reg[k];
        end
        seg_wdata[SGW-1 -: QW] = dur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wp_we)
        begin
            wp_mem[cnt_reg[AW-1:0]] <= wp_wdata;
        end
        wp_rdata_reg <= wp_mem[wp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[i_reg] <= seg_wdata;
        end
        seg_rdata_reg <= seg_mem[i_reg];
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.command)
                        CMD_ADD:    state_next = full_w ? S_DONE : S_ADD_RD;
                        CMD_CLOSE:  state_next = adjust_w ? S_CL_RD0 : S_DONE;
                        CMD_SAMPLE: state_next = sample_bad_w ? S_DONE : S_SM_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_RD:     state_next = (cnt_reg == '0) ? S_DONE : S_ADD_LAT;
            S_ADD_LAT:    state_next = S_JDIV;
            S_JDIV:
            begin
                if (jstep && jlast && spd_phase_reg)
                begin
                    state_next = S_SEG_WR;
                end
                else if (jact && !jsat)
                begin
                    state_next = S_JWAIT;
                end
            end
            S_JWAIT:
            begin
                if (drsp.done)
                begin
                    state_next = (jlast && spd_phase_reg) ? S_SEG_WR : S_JDIV;
                end
            end
            S_SEG_WR:
            begin
                if (req_reg.command == CMD_ADD || cl_last_w)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CL_RD0;
                end
            end
            S_CL_RD0:     state_next = S_CL_RD1;
            S_CL_RD1:     state_next = S_CL_LAT;
            S_CL_LAT:     state_next = S_CL_DIV;
            S_CL_DIV:     state_next = S_CL_DWAIT;
            S_CL_DWAIT:   state_next = drsp.done ? S_JDIV : S_CL_DWAIT;
            S_SM_RD:      state_next = S_SM_CHK;
            S_SM_CHK:
            begin
                if (found_w)
                begin
                    state_next = S_SM_WRD0;
                end
                else if (i_reg == first_reg - 1'b1)
                begin
                    state_next = S_SM_END_RD;
                end
                else
                begin
                    state_next = S_SM_RD;
                end
            end
            S_SM_WRD0:    state_next = S_SM_WRD1;
            S_SM_WRD1:    state_next = S_SM_WLAT;
            S_SM_WLAT:    state_next = S_SM_MUL;
            S_SM_MUL:     state_next = S_SM_POS;
            S_SM_POS:     state_next = jlast ? S_DONE : S_SM_MUL;
            S_SM_END_RD:  state_next = S_SM_END_LAT;
            S_SM_END_LAT: state_next = S_DONE;
            S_DONE:       state_next = load_res ? S_IDLE : S_DONE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Configuration, trajectory bookkeeping and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joints_in_use_reg <= JOINTS_RESET;
            for (int k = 0; k < JOINT_FIELDS; k++)
            begin
                vel_limit_reg[k] <= VEL_RESET;
            end
            cnt_reg       <= '0;
            first_reg     <= '0;
            min_sum_reg   <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_JOINTS)
                begin
                    joints_in_use_reg <= cfg_wdata[2:0];
                end
                for (int k = 0; k < JOINT_FIELDS; k++)
                begin
                    if (cfg_index == CFG_VEL_BASE + CFG_IDX_W'(k))
                    begin
                        vel_limit_reg[k] <= cfg_wdata;
                    end
                end
            end

            if (accept && req.command == CMD_CLOSE && !adjust_w)
            begin
                total_reg   <= sat_add32(total_reg, min_sum_reg);
                first_reg   <= nseg_w;
                min_sum_reg <= '0;
            end

            if (state_reg == S_ADD_RD && cnt_reg == '0)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (state_reg == S_SEG_WR)
            begin
                if (req_reg.command == CMD_ADD)
                begin
                    min_sum_reg <= sat_add32(min_sum_reg, dur_reg);
                    cnt_reg     <= cnt_reg + 1'b1;
                end
                else if (cl_last_w)
                begin
                    total_reg   <= sat_add32(total_reg, req_reg.time_value);
                    first_reg   <= nseg_w;
                    min_sum_reg <= '0;
                end
            end

            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_reg      <= req;
                    status_reg   <= ST_OK;
                    seg_time_reg <= total_reg;
                    acc_reg      <= '0;
                    i_reg        <= (req.command == CMD_CLOSE) ? first_reg : '0;
                    for (int k = 0; k < JOINTS; k++)
                    begin
                        pos_reg[k] <= '0;
                    end
                    if (req.command == CMD_ADD && full_w)
                    begin
                        status_reg <= ST_FULL;
                    end
                    if (req.command == CMD_SAMPLE && sample_bad_w)
                    begin
                        status_reg <= ST_RANGE;
                    end
                    if (req.command == CMD_CLOSE && !adjust_w)
                    begin
                        seg_time_reg <= sat_add32(total_reg, min_sum_reg);
                    end
                end
            end

            S_ADD_LAT:
            begin
                for (int k = 0; k < JOINTS; k++)
                begin
                    a_reg[k]   <= wp_rdata_reg[k*QW +: QW];
                    b_reg[k]   <= req_joint[k];
                    lim_reg[k] <= vel_limit_reg[k];
                end
                j_reg         <= '0;
                spd_phase_reg <= 1'b0;
                dur_reg       <= '0;
                i_reg         <= AW'(cnt_reg - 1'b1);
            end

            S_JDIV, S_JWAIT:
            begin
                if (jstep)
                begin
                    for (int k = 0; k < JOINTS - 1; k++)
                    begin
                        a_reg[k]   <= a_reg[k+1];
                        b_reg[k]   <= b_reg[k+1];
                        lim_reg[k] <= lim_reg[k+1];
                        spd_reg[k] <= spd_reg[k+1];
                    end
                    a_reg[JOINTS-1]   <= a_reg[0];
                    b_reg[JOINTS-1]   <= b_reg[0];
                    lim_reg[JOINTS-1] <= lim_reg[0];
                    if (spd_phase_reg)
                    begin
                        spd_reg[JOINTS-1] <= jres;
                    end
                    else if (jres > dur_reg)
                    begin
                        dur_reg <= jres;
                    end
                    if (jlast)
                    begin
                        j_reg         <= '0;
                        spd_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end

            S_SEG_WR:
            begin
                if (req_reg.command == CMD_ADD)
                begin
                    seg_time_reg <= dur_reg;
                end
                else if (cl_last_w)
                begin
                    seg_time_reg <= sat_add32(total_reg, req_reg.time_value);
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end

            S_CL_RD1:
            begin
                for (int k = 0; k < JOINTS; k++)
                begin
                    a_reg[k] <= wp_rdata_reg[k*QW +: QW];
                end
                dur_old_reg <= seg_dur_w;
            end

            S_CL_LAT, S_SM_WLAT:
            begin
                for (int k = 0; k < JOINTS; k++)
                begin
                    b_reg[k] <= wp_rdata_reg[k*QW +: QW];
                end
                j_reg <= '0;
            end

            S_CL_DWAIT:
            begin
                if (drsp.done)
                begin
                    dur_reg       <= drsp.quotient;
                    spd_phase_reg <= 1'b1;
                    j_reg         <= '0;
                end
            end

            S_SM_CHK:
            begin
                if (found_w)
                begin
                    for (int k = 0; k < JOINTS; k++)
                    begin
                        spd_reg[k] <= seg_rdata_reg[k*QW +: QW];
                    end
                    el_reg <= req_reg.time_value - acc_reg[QW-1:0];
                end
                else
                begin
                    acc_reg <= acc_next;
                    i_reg   <= i_reg + 1'b1;
                end
            end

            S_SM_WRD1:
            begin
                for (int k = 0; k < JOINTS; k++)
                begin
                    a_reg[k] <= wp_rdata_reg[k*QW +: QW];
                end
            end

            S_SM_POS:
            begin
                for (int k = 0; k < JOINTS - 1; k++)
                begin
                    a_reg[k]   <= a_reg[k+1];
                    b_reg[k]   <= b_reg[k+1];
                    spd_reg[k] <= spd_reg[k+1];
                    pos_reg[k] <= pos_reg[k+1];
                end
                a_reg[JOINTS-1]   <= a_reg[0];
                b_reg[JOINTS-1]   <= b_reg[0];
                spd_reg[JOINTS-1] <= spd_reg[0];
                if (3'(j_reg) < n_act)
                begin
                    pos_reg[JOINTS-1] <= sat_pos(a_reg[0], prod_reg[2*QW-1:16],
                                                 b_reg[0] < a_reg[0]);
                end
                else
                begin
                    pos_reg[JOINTS-1] <= '0;
                end
                j_reg <= j_reg + 1'b1;
            end

            S_SM_END_LAT:
            begin
                // Sample at or past the last closed segment's end: last waypoint.
                for (int k = 0; k < JOINTS; k++)
                begin
                    pos_reg[k] <= (3'(k) < n_act) ? wp_rdata_reg[k*QW +: QW] : '0;
                end
            end

            default:
            begin
            end
        endcase

        if (load_res)
        begin
            res_reg.status       <= status_reg;
            res_reg.joint_out_0  <= pos_full[0];
            res_reg.joint_out_1  <= pos_full[1];
            res_reg.joint_out_2  <= pos_full[2];
            res_reg.joint_out_3  <= pos_full[3];
            res_reg.joint_out_4  <= pos_full[4];
            res_reg.joint_out_5  <= pos_full[5];
            res_reg.segment_time <= seg_time_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* design/sjlt_div.sv */
// ----------------------------------------------------------------------------
// sjlt_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in 32 bits (upper dividend half below divisor).
// ----------------------------------------------------------------------------
module sjlt_div
    import sjlt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t dreq,
    output div_rsp_t drsp
);

    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   rem_reg;
    logic [QW-1:0]   low_reg;
    logic [QW-1:0]   den_reg;

    logic [QW:0]     trial;
    logic            fits;

    assign trial = {rem_reg, low_reg[QW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (dreq.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dreq.start)
        begin
            rem_reg <= dreq.dividend[2*QW-1:QW];
            low_reg <= dreq.dividend[QW-1:0];
            den_reg <= dreq.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? QW'(trial - {1'b0, den_reg}) : trial[QW-1:0];
            low_reg <= {low_reg[QW-2:0], fits};
        end
    end

    assign drsp.done     = done_reg;
    assign drsp.quotient = low_reg;

endmodule

/* design/sjlt_checker.sv */
// ----------------------------------------------------------------------------
// sjlt_checker
// Port-level checks for the joint trajectory block, bound to the top level.
// ----------------------------------------------------------------------------
`include "synced_joint_linear_trajectory_macros.svh"

module sjlt_checker
    import sjlt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A stalled result item holds its value.
    `SJLT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))

    // Items are processed one at a time: no back-to-back acceptance.
    `SJLT_ASSERT_NEXT(a_one_item, clk, rst_n, req_valid && req_ready, !req_ready)

    // Error results carry no joint positions.
    `SJLT_ASSERT_SAME(a_err_zero, clk, rst_n, res_valid && res.status != ST_OK, res.joint_out_0 == 0 && res.joint_out_1 == 0 && res.joint_out_2 == 0 && res.joint_out_3 == 0 && res.joint_out_4 == 0 && res.joint_out_5 == 0)

    // Only defined status codes are reported.
    `SJLT_ASSERT_SAME(a_status_code, clk, rst_n, res_valid, res.status == ST_OK || res.status == ST_RANGE || res.status == ST_FULL)

endmodule

bind synced_joint_linear_trajectory sjlt_checker u_sjlt_checker (.*);
